[design/scan_pkg.sv]
`timescale 1ns / 1ps

package scan_pkg;

   // Field and register widths of the ports
   localparam int CYL_W  = 16;
   localparam int MOVE_W = 17;
   localparam int CFG_W  = 17;

   // Defaults for the top-level parameters
   localparam int MAX_REQUESTS_DEF = 64;
   localparam int CYL_BITS_DEF     = 16;

   // Cylinder count after reset
   localparam logic [CFG_W-1:0] RESET_CYLINDERS = 17'd200;

   // Item kinds
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_START = 1'b1;

   // Commands from the sequencer to the datapath
   typedef struct packed {
      logic latch_req;   // take the accepted item
      logic ins_read;    // read the entry below the insertion slot
      logic ins_shift;   // move that entry up one slot
      logic ins_place;   // write the new request, bump the count
      logic scan_read;   // read the entry at the split index
      logic scan_step;   // advance the split index
      logic emit_init;   // set up the service walk
      logic emit_read;   // read the entry to be served
      logic emit_load;   // fill the result register
      logic emit_next;   // advance the service walk
      logic load_empty;  // fill the result register with the empty marker
      logic clear_count; // drop every stored request
   } cmd_type;

   // Status from the datapath to the sequencer
   typedef struct packed {
      logic is_start;    // held item is a start
      logic full;        // store holds the maximum
      logic none;        // store is empty
      logic ins_zero;    // insertion slot reached the bottom
      logic ins_greater; // entry read lies above the new request
      logic scan_cond;   // entry read belongs below the split
      logic scan_last;   // split index is on the final entry
      logic rsp_busy;    // result register still holds an item
      logic rsp_final;   // result register holds the final item
   } status_type;

endpackage

[design/scan_disk_scheduler.sv]
// SCAN disk scheduler: sorted request store, elevator-order service, one item at a time.
// Load item: each stored entry above the new request is moved up one slot, then the request
// is written; a load into a full store is dropped; no result.
// Start item: entries are compared to find the split, then each result is read and loaded,
// waiting out any rsp_ready stall; the next item is taken once the last result has left.
// Synchronous active-high reset empties the store and sets the cylinder count to 200.
`timescale 1ns / 1ps

module scan_disk_scheduler #(
   parameter int MAX_REQUESTS = scan_pkg::MAX_REQUESTS_DEF,
   parameter int CYL_BITS     = scan_pkg::CYL_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_kind,
   input  logic [scan_pkg::CYL_W-1:0]  req_cylinder,
   input  logic                        req_toward_high,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [scan_pkg::CYL_W-1:0]  rsp_served_cylinder,
   output logic [scan_pkg::MOVE_W-1:0] rsp_head_travel,
   output logic                        rsp_last,
   output logic                        rsp_empty_res,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [scan_pkg::CFG_W-1:0]  csr_cylinder_count
);

   scan_pkg::cmd_type    cmd;
   scan_pkg::status_type status;

   scan_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   scan_datapath #(
      .MAX_REQUESTS (MAX_REQUESTS),
      .CYL_BITS     (CYL_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_kind            (req_kind),
      .req_cylinder        (req_cylinder),
      .req_toward_high     (req_toward_high),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_served_cylinder (rsp_served_cylinder),
      .rsp_head_travel     (rsp_head_travel),
      .rsp_last            (rsp_last),
      .rsp_empty_res       (rsp_empty_res),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_cylinder_count  (csr_cylinder_count),
      .cmd                 (cmd),
      .status              (status)
   );

endmodule

[design/scan_ctrl.sv]
`timescale 1ns / 1ps

module scan_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  scan_pkg::status_type status,
   output scan_pkg::cmd_type    cmd
);

   typedef enum logic [8:0] {
      ST_IDLE     = 9'b000000001,
      ST_DECIDE   = 9'b000000010,
      ST_INS_RD   = 9'b000000100,
      ST_INS_CMP  = 9'b000001000,
      ST_SCAN_RD  = 9'b000010000,
      ST_SCAN_CMP = 9'b000100000,
      ST_EMIT_SET = 9'b001000000,
      ST_EMIT_RD  = 9'b010000000,
      ST_EMIT_LD  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      wait_ff, wait_in;

   // Hold the state; wait_ff marks a result waiting to be taken
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wait_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         wait_ff  <= wait_in;
      end
   end

   // Take no item while reset is held
   assign req_ready = (state_ff == ST_IDLE) && !wait_ff && !reset;

   // Sequence the load, scan and service steps
   always_comb begin
      state_in = state_ff;
      wait_in  = wait_ff;
      cmd      = '0;
      if (wait_ff) begin
         // Wait for the result to leave, then go on or finish the sweep
         if (!status.rsp_busy) begin
            wait_in = 1'b0;
            if (status.rsp_final) begin
               cmd.clear_count = 1'b1;
               state_in        = ST_IDLE;
            end else begin
               cmd.emit_next = 1'b1;
               state_in      = ST_EMIT_RD;
            end
         end
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  cmd.latch_req = 1'b1;
                  state_in      = ST_DECIDE;
               end
            end
            ST_DECIDE: begin
               if (!status.is_start) begin
                  state_in = status.full ? ST_IDLE : ST_INS_RD;
               end else if (status.none) begin
                  cmd.load_empty = 1'b1;
                  wait_in        = 1'b1;
                  state_in       = ST_IDLE;
               end else begin
                  state_in = ST_SCAN_RD;
               end
            end
            ST_INS_RD: begin
               if (status.ins_zero) begin
                  cmd.ins_place = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  cmd.ins_read = 1'b1;
                  state_in     = ST_INS_CMP;
               end
            end
            ST_INS_CMP: begin
               if (status.ins_greater) begin
                  cmd.ins_shift = 1'b1;
                  state_in      = ST_INS_RD;
               end else begin
                  cmd.ins_place = 1'b1;
                  state_in      = ST_IDLE;
               end
            end
            ST_SCAN_RD: begin
               cmd.scan_read = 1'b1;
               state_in      = ST_SCAN_CMP;
            end
            ST_SCAN_CMP: begin
               if (status.scan_cond) begin
                  cmd.scan_step = 1'b1;
                  state_in      = status.scan_last ? ST_EMIT_SET : ST_SCAN_RD;
               end else begin
                  state_in = ST_EMIT_SET;
               end
            end
            ST_EMIT_SET: begin
               cmd.emit_init = 1'b1;
               state_in      = ST_EMIT_RD;
            end
            ST_EMIT_RD: begin
               cmd.emit_read = 1'b1;
               state_in      = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
               cmd.emit_load = 1'b1;
               wait_in       = 1'b1;
               state_in      = ST_IDLE;
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

endmodule

[design/scan_datapath.sv]
`timescale 1ns / 1ps

module scan_datapath #(
   parameter int MAX_REQUESTS = scan_pkg::MAX_REQUESTS_DEF,
   parameter int CYL_BITS     = scan_pkg::CYL_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_kind,
   input  logic [scan_pkg::CYL_W-1:0]     req_cylinder,
   input  logic                           req_toward_high,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [scan_pkg::CYL_W-1:0]     rsp_served_cylinder,
   output logic [scan_pkg::MOVE_W-1:0]    rsp_head_travel,
   output logic                           rsp_last,
   output logic                           rsp_empty_res,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [scan_pkg::CFG_W-1:0]     csr_cylinder_count,
   input  scan_pkg::cmd_type              cmd,
   output scan_pkg::status_type           status
);

   localparam int IDX_W  = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
   localparam int CNT_W  = $clog2(MAX_REQUESTS + 1);
   localparam int CYL_W  = scan_pkg::CYL_W;
   localparam int MOVE_W = scan_pkg::MOVE_W;
   localparam int CFG_W  = scan_pkg::CFG_W;
   localparam logic [CFG_W-1:0] CYL_LIMIT = CFG_W'(2 ** CYL_BITS);
   localparam logic [CFG_W-1:0] CYL_FLOOR = CFG_W'(2);
   localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_REQUESTS);

   // Clamp a cylinder to the highest one on the disk
   function automatic logic [CYL_BITS-1:0] clamp_cyl(input logic [CYL_W-1:0] v,
                                                     input logic [CYL_BITS-1:0] top);
      clamp_cyl = (v > CYL_W'(top)) ? top : v[CYL_BITS-1:0];
   endfunction

   logic [CFG_W-1:0]    cyl_count_ff;
   logic [CFG_W-1:0]    cyl_eff;
   logic [CFG_W-1:0]    top_wide;
   logic [CYL_BITS-1:0] top;

   logic [CYL_BITS-1:0] mem [MAX_REQUESTS];
   logic [CYL_BITS-1:0] rdata_ff;
   logic [IDX_W-1:0]    rd_addr;
   logic                rd_en;

   logic [CNT_W-1:0]    count_ff;
   logic                kind_ff;
   logic                high_ff;
   logic [CYL_BITS-1:0] v_ff;
   logic [IDX_W-1:0]    ins_ff;
   logic [CNT_W-1:0]    split_ff;
   logic [CNT_W-1:0]    split_dec;
   logic [IDX_W-1:0]    idx_ff;
   logic                up_ff;
   logic [IDX_W-1:0]    k_ff;

   logic                rsp_valid_ff;
   logic [CYL_BITS-1:0] rsp_cyl_ff;
   logic [MOVE_W-1:0]   rsp_move_ff;
   logic                rsp_last_ff;
   logic                rsp_empty_ff;

   logic [CYL_BITS-1:0] cv;
   logic                emit_last;
   logic [MOVE_W-1:0]   move_total;

   // Hold the cylinder count register; take no write while reset is held
   assign csr_ready = !reset;
   always_ff @(posedge clock) begin
      if (reset) begin
         cyl_count_ff <= scan_pkg::RESET_CYLINDERS;
      end else if (csr_valid) begin
         cyl_count_ff <= csr_cylinder_count;
      end
   end

   // Bound the count and derive the top cylinder
   always_comb begin
      if (cyl_count_ff < CYL_FLOOR) begin
         cyl_eff = CYL_FLOOR;
      end else if (cyl_count_ff > CYL_LIMIT) begin
         cyl_eff = CYL_LIMIT;
      end else begin
         cyl_eff = cyl_count_ff;
      end
      top_wide = cyl_eff - CFG_W'(1);
      top      = top_wide[CYL_BITS-1:0];
   end

   // Pick the read address
   always_comb begin
      rd_en   = cmd.ins_read | cmd.scan_read | cmd.emit_read;
      rd_addr = idx_ff;
      if (cmd.ins_read) begin
         rd_addr = ins_ff - IDX_W'(1);
      end else if (cmd.scan_read) begin
         rd_addr = split_ff[IDX_W-1:0];
      end
   end

   // Request store: one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (cmd.ins_shift) begin
         mem[ins_ff] <= rdata_ff;
      end else if (cmd.ins_place) begin
         mem[ins_ff] <= v_ff;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // Fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.clear_count) begin
         count_ff <= '0;
      end else if (cmd.ins_place) begin
         count_ff <= count_ff + CNT_W'(1);
      end
   end

   assign split_dec = split_ff - CNT_W'(1);

   // Item fields, insertion slot, split index and service walk
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         kind_ff  <= req_kind;
         high_ff  <= req_toward_high;
         v_ff     <= clamp_cyl(req_cylinder, top);
         ins_ff   <= count_ff[IDX_W-1:0];
         split_ff <= '0;
      end
      if (cmd.ins_shift) begin
         ins_ff <= ins_ff - IDX_W'(1);
      end
      if (cmd.scan_step) begin
         split_ff <= split_ff + CNT_W'(1);
      end
      if (cmd.emit_init) begin
         k_ff <= '0;
         if (high_ff) begin
            up_ff  <= (split_ff != count_ff);
            idx_ff <= (split_ff != count_ff) ? split_ff[IDX_W-1:0] : split_dec[IDX_W-1:0];
         end else begin
            up_ff  <= (split_ff == '0);
            idx_ff <= (split_ff == '0) ? IDX_W'(0) : split_dec[IDX_W-1:0];
         end
      end
      if (cmd.emit_next) begin
         k_ff <= k_ff + IDX_W'(1);
         if (up_ff) begin
            // Turn at the highest entry when sweeping high first
            if (high_ff && (CNT_W'(idx_ff) + CNT_W'(1) == count_ff)) begin
               up_ff  <= 1'b0;
               idx_ff <= split_dec[IDX_W-1:0];
            end else begin
               idx_ff <= idx_ff + IDX_W'(1);
            end
         end else begin
            // Turn at the lowest entry when sweeping low first
            if (!high_ff && (idx_ff == '0)) begin
               up_ff  <= 1'b1;
               idx_ff <= split_ff[IDX_W-1:0];
            end else begin
               idx_ff <= idx_ff - IDX_W'(1);
            end
         end
      end
   end

   // Served value, final flag and closed-form travel
   always_comb begin
      cv        = clamp_cyl(CYL_W'(rdata_ff), top);
      emit_last = (CNT_W'(k_ff) + CNT_W'(1) == count_ff);
      if (high_ff) begin
         move_total = MOVE_W'(top) - MOVE_W'(v_ff)
                    + ((split_ff != '0) ? (MOVE_W'(top) - MOVE_W'(cv)) : MOVE_W'(0));
      end else begin
         move_total = MOVE_W'(v_ff) + ((split_ff != count_ff) ? MOVE_W'(cv) : MOVE_W'(0));
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_load || cmd.load_empty) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_load) begin
         rsp_cyl_ff   <= cv;
         rsp_last_ff  <= emit_last;
         rsp_move_ff  <= emit_last ? move_total : '0;
         rsp_empty_ff <= 1'b0;
      end else if (cmd.load_empty) begin
         rsp_cyl_ff   <= '0;
         rsp_last_ff  <= 1'b1;
         rsp_move_ff  <= '0;
         rsp_empty_ff <= 1'b1;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_served_cylinder = CYL_W'(rsp_cyl_ff);
   assign rsp_head_travel     = rsp_move_ff;
   assign rsp_last            = rsp_last_ff;
   assign rsp_empty_res       = rsp_empty_ff;

   // Report to the sequencer
   always_comb begin
      status.is_start    = (kind_ff == scan_pkg::KIND_START);
      status.full        = (count_ff == CNT_MAX);
      status.none        = (count_ff == '0);
      status.ins_zero    = (ins_ff == '0);
      status.ins_greater = (rdata_ff > v_ff);
      status.scan_cond   = high_ff ? (cv < v_ff) : (cv <= v_ff);
      status.scan_last   = (split_ff + CNT_W'(1) == count_ff);
      status.rsp_busy    = rsp_valid_ff;
      status.rsp_final   = rsp_last_ff;
   end

endmodule

[design/scan_checker.sv]
`timescale 1ns / 1ps

module scan_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [scan_pkg::CYL_W-1:0]  rsp_served_cylinder,
   input logic [scan_pkg::MOVE_W-1:0] rsp_head_travel,
   input logic                        rsp_last,
   input logic                        rsp_empty_res
);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_served_cylinder)
         && $stable(rsp_head_travel) && $stable(rsp_last))
      else $error("result changed while stalled");

   // No item is taken while a result waits
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input taken while result pending");

   // The empty marker is a lone final item with zero fields
   a_empty_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_res |-> rsp_last && rsp_served_cylinder == '0
         && rsp_head_travel == '0)
      else $error("malformed empty result");

   // Travel is reported on the final item only
   a_move_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_head_travel == '0)
      else $error("travel shown before the final item");

endmodule

bind scan_disk_scheduler scan_checker u_scan_checker (
   .clock               (clock),
   .reset               (reset),
   .req_ready           (req_ready),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_served_cylinder (rsp_served_cylinder),
   .rsp_head_travel     (rsp_head_travel),
   .rsp_last            (rsp_last),
   .rsp_empty_res       (rsp_empty_res)
);
